@@ rtl/core/ddd_pkg.sv @@
// ----------------------------------------------------------------------------
// ddd_pkg
// Constants and helper functions shared by the date difference core.
// ----------------------------------------------------------------------------
package ddd_pkg;

    localparam int DAY_W   = 5;
    localparam int MON_W   = 4;
    localparam int OUT_W   = 22;
    localparam int DBM_W   = 9;
    localparam int MP_W    = 10;

    localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

    // Division by 100 as a reciprocal multiply: floor(x * 83887 / 2^23) is
    // exact for every x below 2^16.
    localparam int RECIP_W  = 17;
    localparam int RECIP_SH = 23;
    localparam logic [RECIP_W-1:0] RECIP_100 = 17'd83887;

    localparam int DAYS_COMMON = 365;
    localparam int CENTURY     = 100;
    localparam logic [MON_W-1:0] MONTH_MARCH = 4'd3;

    // Days in the months before the given month of a common year. Month
    // codes above twelve keep adding 31 days per step.
    function automatic logic [DBM_W-1:0] days_before_month(input logic [MON_W-1:0] m);
        logic [DBM_W-1:0] d;
        unique case (m)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            4'd13:   d = 9'd365;
            4'd14:   d = 9'd396;
            4'd15:   d = 9'd427;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

@@ rtl/core/date_difference_days_core.sv @@
// ----------------------------------------------------------------------------
// date_difference_days_core
// Absolute distance in days between two proleptic Gregorian dates.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (i_valid / o_stall) carries one pair of dates per
//   transaction. The output channel (o_valid / i_stall) returns one
//   transaction with o_days_apart for every input transaction, in order.
//   Each date becomes a day number: 365 days per earlier year, the earlier
//   leap years, the earlier months and the day. Years above MAX_YEAR are
//   clamped, and a distance beyond the output range saturates.
//   The block is a five-stage pipeline (clamp and month lookup, reciprocal
//   multiply for the century count, year and month sums, day numbers,
//   difference and saturation) and accepts one transaction every cycle
//   while o_stall is low.
//   When i_stall holds a result, the stages behind it keep filling until
//   they are all occupied; only then is o_stall raised. Nothing is lost or
//   repeated while stalled.
//   Reset (synchronous, active low) empties every stage; the block can take
//   a transaction in the first cycle after reset is released.
// ----------------------------------------------------------------------------
module date_difference_days_core #(
    parameter int MAX_YEAR = 9999
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [ddd_pkg::DAY_W-1:0]     i_first_day,
    input  logic [ddd_pkg::MON_W-1:0]     i_first_month,
    input  logic [$clog2(MAX_YEAR+1)-1:0] i_first_year,
    input  logic [ddd_pkg::DAY_W-1:0]     i_second_day,
    input  logic [ddd_pkg::MON_W-1:0]     i_second_month,
    input  logic [$clog2(MAX_YEAR+1)-1:0] i_second_year,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [ddd_pkg::OUT_W-1:0]     o_days_apart
);

    localparam int YW     = $clog2(MAX_YEAR + 1);
    localparam int QW     = $clog2(MAX_YEAR / 100 + 1);
    localparam int PW     = YW + ddd_pkg::RECIP_W;
    localparam int DN_MAX = MAX_YEAR * 366 + 427 + 1 + 31;
    localparam int DN_W   = $clog2(DN_MAX + 1);
    localparam int CW     = (DN_W > ddd_pkg::OUT_W) ? DN_W : ddd_pkg::OUT_W;
    localparam int NS     = 5;

    // Pipeline control
    logic [NS-1:0] r_vld;
    logic [NS-1:0] rdy;

    always_comb begin
        rdy[NS-1] = !r_vld[NS-1] || !i_stall;
        for (int k = NS - 2; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end

    assign o_stall = !rdy[0];
    assign o_valid = r_vld[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Stage 1: clamp the year, take the count of earlier years, look up months.
    logic [YW-1:0]                 in_year [2];
    logic [ddd_pkg::MON_W-1:0]     in_month [2];
    logic [ddd_pkg::DAY_W-1:0]     in_day [2];
    logic [YW-1:0]                 n_ysat [2];
    logic [YW-1:0]                 n_prior [2];
    logic [ddd_pkg::DBM_W-1:0]     n_dbm [2];

    logic [YW-1:0]                 r1_ysat [2];
    logic [YW-1:0]                 r1_prior [2];
    logic [ddd_pkg::DBM_W-1:0]     r1_dbm [2];
    logic                          r1_late [2];
    logic [ddd_pkg::DAY_W-1:0]     r1_day [2];

    assign in_year[0]  = i_first_year;
    assign in_year[1]  = i_second_year;
    assign in_month[0] = i_first_month;
    assign in_month[1] = i_second_month;
    assign in_day[0]   = i_first_day;
    assign in_day[1]   = i_second_day;

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            n_ysat[i]  = (in_year[i] > YW'(MAX_YEAR)) ? YW'(MAX_YEAR) : in_year[i];
            n_prior[i] = (n_ysat[i] == '0) ? '0 : n_ysat[i] - YW'(1);
            n_dbm[i]   = ddd_pkg::days_before_month(in_month[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            for (int i = 0; i < 2; i++) begin
                r1_ysat[i]  <= n_ysat[i];
                r1_prior[i] <= n_prior[i];
                r1_dbm[i]   <= n_dbm[i];
                r1_late[i]  <= in_month[i] >= ddd_pkg::MONTH_MARCH;
                r1_day[i]   <= in_day[i];
            end
        end
    end

    // Stage 2: divide the year and the earlier-year count by 100.
    logic [PW-1:0]                 prod_p [2];
    logic [PW-1:0]                 prod_y [2];

    logic [YW-1:0]                 r2_ysat [2];
    logic [YW-1:0]                 r2_prior [2];
    logic [QW-1:0]                 r2_qp [2];
    logic [QW-1:0]                 r2_qy [2];
    logic [ddd_pkg::DBM_W-1:0]     r2_dbm [2];
    logic                          r2_late [2];
    logic [ddd_pkg::DAY_W-1:0]     r2_day [2];

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            prod_p[i] = PW'(r1_prior[i]) * PW'(ddd_pkg::RECIP_100);
            prod_y[i] = PW'(r1_ysat[i]) * PW'(ddd_pkg::RECIP_100);
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            for (int i = 0; i < 2; i++) begin
                r2_ysat[i]  <= r1_ysat[i];
                r2_prior[i] <= r1_prior[i];
                r2_qp[i]    <= prod_p[i][ddd_pkg::RECIP_SH +: QW];
                r2_qy[i]    <= prod_y[i][ddd_pkg::RECIP_SH +: QW];
                r2_dbm[i]   <= r1_dbm[i];
                r2_late[i]  <= r1_late[i];
                r2_day[i]   <= r1_day[i];
            end
        end
    end

    // Stage 3: days of the earlier years, and days within the year.
    // Dividing the century quotient by four gives the count of 400-year spans.
    logic                          cent [2];
    logic                          leap [2];
    logic [DN_W-1:0]               n_ypart [2];
    logic [ddd_pkg::MP_W-1:0]      n_mpart [2];

    logic [DN_W-1:0]               r3_ypart [2];
    logic [ddd_pkg::MP_W-1:0]      r3_mpart [2];

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            cent[i]    = r2_ysat[i] == YW'(int'(r2_qy[i]) * ddd_pkg::CENTURY);
            leap[i]    = ((r2_ysat[i][1:0] == 2'b00) && !cent[i])
                      || (cent[i] && (r2_qy[i][1:0] == 2'b00));
            n_ypart[i] = DN_W'(r2_prior[i]) * DN_W'(ddd_pkg::DAYS_COMMON)
                       + DN_W'(r2_prior[i] >> 2)
                       - DN_W'(r2_qp[i])
                       + DN_W'(r2_qp[i] >> 2);
            n_mpart[i] = ddd_pkg::MP_W'(r2_dbm[i])
                       + ddd_pkg::MP_W'(r2_late[i] && leap[i])
                       + ddd_pkg::MP_W'(r2_day[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[2]) begin
            for (int i = 0; i < 2; i++) begin
                r3_ypart[i] <= n_ypart[i];
                r3_mpart[i] <= n_mpart[i];
            end
        end
    end

    // Stage 4: day numbers.
    logic [DN_W-1:0]               r4_dn [2];

    always_ff @(posedge i_clk) begin
        if (rdy[3]) begin
            for (int i = 0; i < 2; i++) begin
                r4_dn[i] <= r3_ypart[i] + DN_W'(r3_mpart[i]);
            end
        end
    end

    // Stage 5: absolute difference, saturated to the output range.
    logic [CW-1:0]                 n_diff;
    logic [ddd_pkg::OUT_W-1:0]     n_days_apart;
    logic [ddd_pkg::OUT_W-1:0]     r_days_apart;

    always_comb begin
        if (r4_dn[0] >= r4_dn[1]) begin
            n_diff = CW'(r4_dn[0] - r4_dn[1]);
        end else begin
            n_diff = CW'(r4_dn[1] - r4_dn[0]);
        end
        if (n_diff > CW'(ddd_pkg::OUT_MAX)) begin
            n_days_apart = ddd_pkg::OUT_MAX;
        end else begin
            n_days_apart = ddd_pkg::OUT_W'(n_diff);
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[NS-1]) begin
            r_days_apart <= n_days_apart;
        end
    end

    assign o_days_apart = r_days_apart;

`ifndef SYNTHESIS
    // The input side is held off only when every stage holds a transaction.
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> ((&r_vld) && i_stall))
        else $error("input stalled while the pipeline has a free stage");

    // A transaction in the middle stage moves on when the next stage is empty.
    a_mid_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[2] && !r_vld[3]) |=> r_vld[3])
        else $error("transaction did not advance into an empty stage");

    // A delivered result leaves the output empty if nothing was behind it.
    a_out_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !r_vld[NS-2]) |=> !o_valid)
        else $error("output transaction repeated after delivery");
`endif

endmodule
